// File: hw/rtl/ctd_pkg.sv
// Package for the chunked transfer decoder: sizes, phase codes, status codes
// and the hex digit decode function. Used by chunked_transfer_decoder.
// No dependencies.
package ctd_pkg;

    localparam int SIZE_LINE_MAX = 19;
    localparam int COUNT_BITS    = 32;
    localparam int LINE_BITS     = $clog2(SIZE_LINE_MAX + 1);
    localparam int TOTAL_BITS    = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [5:0] {
        PH_SIZE      = 6'b000001,
        PH_SKIP_LF   = 6'b000010,
        PH_PAYLOAD   = 6'b000100,
        PH_SKIP_CRLF = 6'b001000,
        PH_DONE      = 6'b010000,
        PH_ERROR     = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_FINISHED = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            d.value = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            d.value = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            d.value = 4'(c - 8'h37);
        else
            d.is_hex = 1'b0;
        return d;
    endfunction

endpackage

// File: hw/rtl/chunked_transfer_decoder.sv
// Chunked transfer decoder: one body byte in, one result out per transaction.
// A result is held in the output register from the cycle after its byte is taken.
// Throughput: one byte per cycle while results are taken; the parser state updates in a
// single pass per byte. A stalled result holds s_axis_tready low until it is taken.
// Reset (rst_n low, asynchronous) puts the parser at the start of a size line with
// zero counts and an empty output register. Depends on ctd_pkg.
module chunked_transfer_decoder
    import ctd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [39:8] payload_total
    output logic [2:0]  m_axis_tuser    // [0] payload_valid, [2:1] status
);

    phase_t                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   size_accum_reg, size_accum_next;
    logic [LINE_BITS-1:0]    line_chars_reg, line_chars_next;
    logic                    hex_stopped_reg, hex_stopped_next;
    logic [COUNT_BITS-1:0]   bytes_left_reg, bytes_left_next;
    logic [1:0]              skip_left_reg, skip_left_next;
    logic [COUNT_BITS-1:0]   total_count_reg, total_count_next;

    logic                    out_valid_reg;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic                    out_pvalid_reg, out_pvalid_next;
    status_t                 out_status_reg, out_status_next;
    logic [TOTAL_BITS-1:0]   out_total_reg;

    logic                    s_fire;
    logic [7:0]              c;
    hex_digit_t              hd;
    phase_t                  ph;
    logic [COUNT_BITS-1:0]   sa, bl, tc;
    logic [LINE_BITS-1:0]    lc;
    logic                    hs;
    logic [1:0]              sl;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;
    assign hd            = hex_decode(c);

    always_comb
    begin
        // restart clears the parser before this byte is handled
        if (s_axis_tuser)
        begin
            ph = PH_SIZE;
            sa = '0;
            lc = '0;
            hs = 1'b0;
            bl = '0;
            sl = '0;
            tc = '0;
        end
        else
        begin
            ph = phase_reg;
            sa = size_accum_reg;
            lc = line_chars_reg;
            hs = hex_stopped_reg;
            bl = bytes_left_reg;
            sl = skip_left_reg;
            tc = total_count_reg;
        end

        phase_next       = ph;
        size_accum_next  = sa;
        line_chars_next  = lc;
        hex_stopped_next = hs;
        bytes_left_next  = bl;
        skip_left_next   = sl;
        total_count_next = tc;
        out_pvalid_next  = 1'b0;

        case (ph)
            PH_SIZE:
            begin
                if (c != CHAR_CR && lc < LINE_BITS'(SIZE_LINE_MAX))
                begin
                    line_chars_next = lc + 1'b1;
                    if (!hs)
                    begin
                        if (!hd.is_hex)
                            hex_stopped_next = 1'b1;
                        else if (sa[COUNT_BITS-1 -: 4] != 4'd0)
                            phase_next = PH_ERROR;
                        else
                            size_accum_next = {sa[COUNT_BITS-5:0], hd.value};
                    end
                end
                else
                begin
                    phase_next = PH_SKIP_LF;
                end
            end
            PH_SKIP_LF:
            begin
                if (sa == '0)
                    phase_next = PH_DONE;
                else
                begin
                    bytes_left_next = sa;
                    phase_next      = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                out_pvalid_next  = 1'b1;
                total_count_next = tc + 1'b1;
                bytes_left_next  = bl - 1'b1;
                if (bl == COUNT_BITS'(1))
                begin
                    skip_left_next = 2'd2;
                    phase_next     = PH_SKIP_CRLF;
                end
            end
            PH_SKIP_CRLF:
            begin
                skip_left_next = sl - 1'b1;
                if (sl == 2'd1)
                begin
                    phase_next       = PH_SIZE;
                    size_accum_next  = '0;
                    line_chars_next  = '0;
                    hex_stopped_next = 1'b0;
                end
            end
            default:
            begin
                // done or error: drop the byte and hold
            end
        endcase

        out_byte_next = out_pvalid_next ? c : 8'd0;

        case (phase_next)
            PH_SIZE, PH_SKIP_LF, PH_PAYLOAD, PH_SKIP_CRLF: out_status_next = ST_BUSY;
            PH_DONE:                                       out_status_next = ST_FINISHED;
            default:                                       out_status_next = ST_OVERFLOW;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SIZE;
            size_accum_reg  <= '0;
            line_chars_reg  <= '0;
            hex_stopped_reg <= 1'b0;
            bytes_left_reg  <= '0;
            skip_left_reg   <= '0;
            total_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                phase_reg       <= phase_next;
                size_accum_reg  <= size_accum_next;
                line_chars_reg  <= line_chars_next;
                hex_stopped_reg <= hex_stopped_next;
                bytes_left_reg  <= bytes_left_next;
                skip_left_reg   <= skip_left_next;
                total_count_reg <= total_count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_byte_reg   <= out_byte_next;
            out_pvalid_reg <= out_pvalid_next;
            out_status_reg <= out_status_next;
            out_total_reg  <= TOTAL_BITS'(total_count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_total_reg, out_byte_reg};
    assign m_axis_tuser  = {out_status_reg, out_pvalid_reg};

    // A payload byte never leaves alongside a finished or error status
    a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == ST_BUSY))
        else $error("payload byte with non-busy status");

    // A held result blocks the input side
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result is stalled");

    // Each payload transaction advances the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !s_axis_tuser && phase_reg == PH_PAYLOAD)
            |=> (total_count_reg == $past(total_count_reg) + 1'b1))
        else $error("payload count did not advance");

    // Payload phase always has bytes still due
    a_bytes_due: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (bytes_left_reg != '0))
        else $error("payload phase with no bytes left");

endmodule
